/* hw/rtl/ghalloc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

  // Default pool size and register reset value
  localparam int unsigned SLOTS_DEF = 1024;
  localparam logic [10:0] MAX_SLOTS_RST = 11'd1024;

  // Width used for limit / counter compares (holds up to 65536)
  localparam int unsigned CMP_W = 17;

  // Request codes
  localparam logic [1:0] MODE_CREATE  = 2'd0;
  localparam logic [1:0] MODE_DESTROY = 2'd1;
  localparam logic [1:0] MODE_CHECK   = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Invalid handle
  localparam logic [23:0] INVALID_INDEX = 24'hFFFFFF;
  localparam logic [7:0]  INVALID_GEN   = 8'hFF;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_QRD   = 5'b00100,
    ST_GRD   = 5'b01000,
    ST_EXEC  = 5'b10000
  } ghalloc_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clr_en;    // clearing pass: zero one generation entry
    logic latch_in;  // capture request fields
    logic q_rd;      // read free queue at head
    logic g_rd;      // pick slot index, read its generation
    logic exec;      // update state, write memories, load result
  } ghalloc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_done;  // last entry of clearing pass
  } ghalloc_sts_t;

endpackage : ghalloc_pkg
`default_nettype wire

/* hw/rtl/ghalloc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghalloc_ctrl
// Sequencer: clearing pass, then accept / queue read / generation read /
// execute per transaction. Owns the handshake and the result valid flag.
// ----------------------------------------------------------------------------
module ghalloc_ctrl
  import ghalloc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ghalloc_cmd_t      cmd,
  input  wire ghalloc_sts_t sts
);

  ghalloc_state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_QRD;
        end
      end
      ST_QRD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = ST_GRD;
      end
      ST_GRD: begin
        cmd.g_rd  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // result register free, or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Result valid only comes up from an execute step
  a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.exec))
    else $error("result valid without execute");

  // A held result stalls the execute step
  a_exec_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && out_valid_r && !out_ready |=> (state_r == ST_EXEC))
    else $error("execute overwrote a pending result");

  // No transaction taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_ready)
    else $error("input accepted while clearing");

endmodule : ghalloc_ctrl
`default_nettype wire

/* hw/rtl/ghalloc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghalloc_dp
// Datapath: generation memory, free-index ring, counters, config register
// and the result register.
// ----------------------------------------------------------------------------
module ghalloc_dp
  import ghalloc_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
)(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ghalloc_cmd_t cmd,
  output ghalloc_sts_t      sts,
  input  wire logic         cfg_we,
  input  wire logic [10:0]  cfg_wdata,
  input  wire logic [1:0]   in_mode,
  input  wire logic [23:0]  in_handle_index,
  input  wire logic [7:0]   in_handle_generation,
  output logic [23:0]       out_result_index,
  output logic [7:0]        out_result_generation,
  output logic              out_handle_live,
  output logic [1:0]        out_status
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = CW + 1;
  localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);

  // Memories
  logic [7:0]    gen_mem [SLOTS];
  logic [IW-1:0] q_mem   [SLOTS];

  // Control state
  logic [10:0]   max_slots_r;
  logic [IW-1:0] clr_idx_r;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] free_count_r, free_count_nxt;
  logic [CW-1:0] slots_issued_r, slots_issued_nxt;

  // Request and intermediate payload
  logic [1:0]    mode_r;
  logic [23:0]   hidx_r;
  logic [7:0]    hgen_r;
  logic [IW-1:0] q_rdata_r;
  logic [IW-1:0] idx_r, idx_sel;
  logic [7:0]    g_rdata_r;

  // Result register
  logic [23:0]   res_idx_r;
  logic [7:0]    res_gen_r;
  logic          res_live_r;
  logic [1:0]    res_status_r;

  logic [23:0]   res_idx;
  logic [7:0]    res_gen;
  logic          res_live;
  logic [1:0]    res_status;

  logic [10:0]   limit;
  logic          in_range, q_nonempty, q_full, fresh_ok;
  logic [TW-1:0] tail_sum, tail_wrap;
  logic [IW-1:0] tail, head_inc;
  logic          gen_we, gen_we_x, q_we;
  logic [IW-1:0] gen_waddr;
  logic [7:0]    gen_wdata, gen_wdata_x;

  // Effective limit: min(max_slots, SLOTS)
  assign limit = ({(CMP_W-11)'(0), max_slots_r} > SLOTS_C) ? SLOTS_C[10:0] : max_slots_r;

  assign in_range   = hidx_r < {13'd0, limit};
  assign q_nonempty = free_count_r != '0;
  assign q_full     = free_count_r == CW'(SLOTS);
  assign fresh_ok   = CMP_W'(slots_issued_r) < CMP_W'(limit);

  assign tail_sum  = TW'(free_head_r) + TW'(free_count_r);
  assign tail_wrap = (tail_sum >= TW'(SLOTS)) ? tail_sum - TW'(SLOTS) : tail_sum;
  assign tail      = tail_wrap[IW-1:0];
  assign head_inc  = (free_head_r == IW'(SLOTS - 1)) ? '0 : free_head_r + 1'b1;

  assign sts.clr_done = clr_idx_r == IW'(SLOTS - 1);

  // Slot picked for the generation read
  always_comb begin
    if (mode_r == MODE_CREATE && q_nonempty) idx_sel = q_rdata_r;
    else if (mode_r == MODE_CREATE)          idx_sel = slots_issued_r[IW-1:0];
    else                                     idx_sel = hidx_r[IW-1:0];
  end

  // Execute step
  always_comb begin
    res_idx          = INVALID_INDEX;
    res_gen          = INVALID_GEN;
    res_live         = 1'b0;
    res_status       = STATUS_OK;
    gen_we_x         = 1'b0;
    gen_wdata_x      = '0;
    q_we             = 1'b0;
    free_head_nxt    = free_head_r;
    free_count_nxt   = free_count_r;
    slots_issued_nxt = slots_issued_r;
    unique case (mode_r)
      MODE_CREATE: begin
        if (q_nonempty) begin
          res_idx        = 24'(idx_r);
          res_gen        = g_rdata_r;
          free_head_nxt  = head_inc;
          free_count_nxt = free_count_r - 1'b1;
        end else if (fresh_ok) begin
          res_idx          = 24'(idx_r);
          res_gen          = '0;
          gen_we_x         = 1'b1;
          slots_issued_nxt = slots_issued_r + 1'b1;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      MODE_DESTROY: begin
        if (!in_range) begin
          res_status = STATUS_RANGE;
        end else begin
          gen_we_x    = 1'b1;
          gen_wdata_x = g_rdata_r + 8'd1;
          if (!q_full) begin
            q_we           = 1'b1;
            free_count_nxt = free_count_r + 1'b1;
          end else begin
            res_status = STATUS_FULL;
          end
        end
      end
      MODE_CHECK: begin
        if (!in_range) res_status = STATUS_RANGE;
        else           res_live   = hgen_r == g_rdata_r;
      end
      MODE_NOP: ;
      default: ;
    endcase
  end

  assign gen_we    = cmd.clr_en || (cmd.exec && gen_we_x);
  assign gen_waddr = cmd.clr_en ? clr_idx_r : idx_r;
  assign gen_wdata = cmd.clr_en ? 8'd0 : gen_wdata_x;

  always_ff @(posedge clk) begin
    if (gen_we)    gen_mem[gen_waddr] <= gen_wdata;
    if (cmd.g_rd)  g_rdata_r <= gen_mem[idx_sel];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && q_we) q_mem[tail] <= hidx_r[IW-1:0];
    if (cmd.q_rd)         q_rdata_r <= q_mem[free_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slots_r    <= MAX_SLOTS_RST;
      clr_idx_r      <= '0;
      free_head_r    <= '0;
      free_count_r   <= '0;
      slots_issued_r <= '0;
    end else begin
      if (cfg_we)     max_slots_r <= cfg_wdata;
      if (cmd.clr_en) clr_idx_r   <= clr_idx_r + 1'b1;
      if (cmd.exec) begin
        free_head_r    <= free_head_nxt;
        free_count_r   <= free_count_nxt;
        slots_issued_r <= slots_issued_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r <= in_mode;
      hidx_r <= in_handle_index;
      hgen_r <= in_handle_generation;
    end
    if (cmd.g_rd) idx_r <= idx_sel;
    if (cmd.exec) begin
      res_idx_r    <= res_idx;
      res_gen_r    <= res_gen;
      res_live_r   <= res_live;
      res_status_r <= res_status;
    end
  end

  assign out_result_index      = res_idx_r;
  assign out_result_generation = res_gen_r;
  assign out_handle_live       = res_live_r;
  assign out_status            = res_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(free_count_r) <= SLOTS_C)
    else $error("free count past ring size");

  a_issued_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(slots_issued_r) <= SLOTS_C)
    else $error("issued slots past pool size");

  a_no_write_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && q_full |-> !q_we)
    else $error("push into full free queue");

endmodule : ghalloc_dp
`default_nettype wire

/* hw/rtl/generational_handle_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out (index, generation) handles from a pool of SLOTS slots.
// ----------------------------------------------------------------------------
// Each input transaction is one request: create, destroy or check, and yields
// exactly one result transaction. Create pops the oldest freed index from a
// ring buffer, else issues a fresh slot (generation zero), else returns the
// invalid handle 0xFFFFFF/0xFF with status 1. Destroy bumps the slot's
// generation and queues the index (status 1 when the ring is full, status 2
// when the index is at or past min(max_slots, SLOTS)). Check reports whether
// the handle's generation matches the slot. Mode 3 is a no-op.
// Steps per request: accept, free-queue read, generation read, execute,
// with no new request taken before the execute; the chained queue read then
// generation read through the two registered-read memories sets this order.
// A result waiting in the output register does not block acceptance of the
// next request, only its execute. After reset, in_ready stays low while a
// clearing pass zeroes the generation memory one entry a cycle. Configuration
// writes are taken at any time but should only be issued while idle.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import ghalloc_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF  // pool size, 2..65536
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config: max_slots
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [23:0] in_handle_index,
  input  wire logic [7:0]  in_handle_generation,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_result_index,
  output logic [7:0]       out_result_generation,
  output logic             out_handle_live,
  output logic [1:0]       out_status
);

  ghalloc_cmd_t cmd;
  ghalloc_sts_t sts;

  // Sequencer: handshake and step commands
  ghalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Memories, counters and result register
  ghalloc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_mode               (in_mode),
    .in_handle_index       (in_handle_index),
    .in_handle_generation  (in_handle_generation),
    .out_result_index      (out_result_index),
    .out_result_generation (out_result_generation),
    .out_handle_live       (out_handle_live),
    .out_status            (out_status)
  );

endmodule : generational_handle_allocator
`default_nettype wire

/* verif/tb_generational_handle_allocator.sv */
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator
// Self-checking testbench for the generational handle allocator.
// ----------------------------------------------------------------------------
// A directed table is walked first. Rows with hand-typed results cover reset
// state, index extremes and error codes. Rows without them, and the random
// part that follows, are checked against a predictor kept inside this bench.
// The random part runs in phases at several max_slots settings, from an empty
// pool to a value above the pool size. Both channels stall at random in two
// idle profiles, and a third runs with no stalls.
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator;
  import ghalloc_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEF;
  // Bounds the slowest legal run: clearing pass plus ~930 transactions, each
  // paying the full request sequence and long stalls on both sides, with wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 150;

  // One request transaction and one result transaction.
  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] index;
    logic [7:0]  gen;
  } req_t;

  typedef struct packed {
    logic [23:0] index;
    logic [7:0]  gen;
    logic        live;
    logic [1:0]  status;
  } rsp_t;

  // Directed rows: typed result, predicted result, or a max_slots write.
  typedef enum logic [1:0] {
    ROW_LIT,
    ROW_PRED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  mode;
    logic [23:0] index;
    logic [7:0]  gen;
    logic [10:0] cfg_val;
    rsp_t        res;
  } row_t;

  // Shorthand for results that carry the invalid handle.
  localparam rsp_t NO_RSP  = '0;
  localparam rsp_t R_LIVE  = '{INVALID_INDEX, INVALID_GEN, 1'b1, STATUS_OK};
  localparam rsp_t R_OK    = '{INVALID_INDEX, INVALID_GEN, 1'b0, STATUS_OK};
  localparam rsp_t R_RANGE = '{INVALID_INDEX, INVALID_GEN, 1'b0, STATUS_RANGE};
  localparam rsp_t R_FULL  = '{INVALID_INDEX, INVALID_GEN, 1'b0, STATUS_FULL};

  localparam int unsigned PLAN_LEN = 28;
  localparam row_t PLAN [PLAN_LEN] = '{
    // fresh pool, max_slots at reset value: every generation is zero
    '{ROW_LIT,  MODE_CHECK,   24'd0,         8'd0,   11'd0, R_LIVE},
    '{ROW_LIT,  MODE_CHECK,   24'd0,         8'hFF,  11'd0, R_OK},
    '{ROW_LIT,  MODE_CHECK,   24'd1023,      8'd0,   11'd0, R_LIVE},
    '{ROW_LIT,  MODE_CHECK,   24'd1024,      8'd0,   11'd0, R_RANGE},
    '{ROW_LIT,  MODE_CHECK,   INVALID_INDEX, 8'hFF,  11'd0, R_RANGE},
    // fresh slots come out in order, request fields ignored
    '{ROW_LIT,  MODE_CREATE,  24'd0,         8'd0,   11'd0, '{24'd0, 8'd0, 1'b0, STATUS_OK}},
    '{ROW_LIT,  MODE_CREATE,  INVALID_INDEX, 8'hFF,  11'd0, '{24'd1, 8'd0, 1'b0, STATUS_OK}},
    // destroy makes the old handle stale
    '{ROW_LIT,  MODE_DESTROY, 24'd0,         8'd0,   11'd0, R_OK},
    '{ROW_LIT,  MODE_CHECK,   24'd0,         8'd0,   11'd0, R_OK},
    '{ROW_LIT,  MODE_CHECK,   24'd0,         8'd1,   11'd0, R_LIVE},
    // same index destroyed twice is queued twice
    '{ROW_PRED, MODE_DESTROY, 24'd0,         8'hFF,  11'd0, NO_RSP},
    '{ROW_LIT,  MODE_DESTROY, INVALID_INDEX, 8'd0,   11'd0, R_RANGE},
    '{ROW_LIT,  MODE_DESTROY, 24'd1024,      8'd0,   11'd0, R_RANGE},
    '{ROW_LIT,  MODE_NOP,     INVALID_INDEX, 8'hFF,  11'd0, R_OK},
    '{ROW_LIT,  MODE_CREATE,  24'd0,         8'd0,   11'd0, '{24'd0, 8'd2, 1'b0, STATUS_OK}},
    '{ROW_LIT,  MODE_CREATE,  24'd0,         8'd0,   11'd0, '{24'd0, 8'd2, 1'b0, STATUS_OK}},
    '{ROW_LIT,  MODE_CREATE,  24'd0,         8'd0,   11'd0, '{24'd2, 8'd0, 1'b0, STATUS_OK}},
    // top slot, never issued, still in range
    '{ROW_PRED, MODE_DESTROY, 24'd1023,      8'd0,   11'd0, NO_RSP},
    '{ROW_PRED, MODE_CREATE,  24'd0,         8'd0,   11'd0, NO_RSP},
    // empty pool: nothing in range, nothing to issue
    '{ROW_CFG,  MODE_NOP,     24'd0,         8'd0,   11'd0, NO_RSP},
    '{ROW_LIT,  MODE_CREATE,  24'd0,         8'd0,   11'd0, R_FULL},
    '{ROW_LIT,  MODE_CHECK,   24'd0,         8'd0,   11'd0, R_RANGE},
    '{ROW_LIT,  MODE_DESTROY, 24'd0,         8'd0,   11'd0, R_RANGE},
    // queue index 2, then lower the limit below it: the pop still hands it out
    '{ROW_CFG,  MODE_NOP,     24'd0,         8'd0,   11'd3, NO_RSP},
    '{ROW_PRED, MODE_DESTROY, 24'd2,         8'd0,   11'd0, NO_RSP},
    '{ROW_CFG,  MODE_NOP,     24'd0,         8'd0,   11'd1, NO_RSP},
    '{ROW_PRED, MODE_CREATE,  24'd0,         8'd0,   11'd0, NO_RSP},
    '{ROW_PRED, MODE_CREATE,  24'd0,         8'd0,   11'd0, NO_RSP}
  };

  // Random max_slots per phase; the last phase draws its own value.
  localparam logic [10:0] PHASE_MAX [RAND_PHASES] = '{
    11'd2047, 11'd1024, 11'd5, 11'd1, 11'd0, 11'd0
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_NOP;
  logic [23:0] in_handle_index = '0;
  logic [7:0]  in_handle_generation = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_result_index;
  logic [7:0]  out_result_generation;
  logic        out_handle_live;
  logic [1:0]  out_status;

  // Predictor state: slot generations, free ring, fresh-slot counter.
  logic [7:0]  slot_gen_m [SLOTS] = '{default: '0};
  logic [9:0]  free_ring_m [SLOTS] = '{default: '0};
  int unsigned ring_head_m = 0;
  int unsigned ring_count_m = 0;
  int unsigned issued_m = 0;
  logic [10:0] max_slots_m = MAX_SLOTS_RST;

  rsp_t        replies_due [$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle = 35;  // percent of cycles the sender holds off
  int unsigned recv_idle = 81;  // percent of cycles the receiver stalls

  always #1 clk = ~clk;

  generational_handle_allocator #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_index     (out_result_index),
    .out_result_generation(out_result_generation),
    .out_handle_live      (out_handle_live),
    .out_status           (out_status)
  );

  // Register value above the pool size is clipped to the pool size.
  function automatic int unsigned pool_limit();
    return (max_slots_m > SLOTS) ? SLOTS : int'(max_slots_m);
  endfunction

  // Advances the predictor by one accepted request and returns its result.
  function automatic rsp_t predict_allocation(input req_t r);
    rsp_t        o;
    int unsigned lim;
    int unsigned slot;
    bit          got;
    o = R_OK;
    lim = pool_limit();
    got = 1'b0;
    slot = 0;
    case (r.mode)
      MODE_CREATE: begin
        // oldest freed index wins, even past a lowered limit
        if (ring_count_m > 0) begin
          slot = free_ring_m[ring_head_m];
          ring_head_m = (ring_head_m + 1) % SLOTS;
          ring_count_m--;
          got = 1'b1;
        end else if (issued_m < lim) begin
          slot = issued_m;
          slot_gen_m[slot] = '0;
          issued_m++;
          got = 1'b1;
        end
        if (got) begin
          o.index = 24'(slot);
          o.gen = slot_gen_m[slot];
        end else begin
          o.status = STATUS_FULL;
        end
      end
      MODE_DESTROY: begin
        if (r.index >= lim) begin
          o.status = STATUS_RANGE;
        end else begin
          // generation bumps even when the push is dropped
          slot_gen_m[r.index] = slot_gen_m[r.index] + 8'd1;
          if (ring_count_m < SLOTS) begin
            free_ring_m[(ring_head_m + ring_count_m) % SLOTS] = r.index[9:0];
            ring_count_m++;
          end else begin
            o.status = STATUS_FULL;
          end
        end
      end
      MODE_CHECK: begin
        if (r.index >= lim) o.status = STATUS_RANGE;
        else o.live = (r.gen == slot_gen_m[r.index]);
      end
      default: ;
    endcase
    return o;
  endfunction

  // Presents one request, holds it until the handshake, then records the
  // expected result. A typed result overrides the prediction, but the
  // predictor still runs so its state follows the block.
  task automatic send_request(input req_t r, input bit typed, input rsp_t lit);
    rsp_t res;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_handle_index <= r.index;
    in_handle_generation <= r.gen;
    // in_ready follows registered state only, so it is settled by the
    // falling edge; the rising edge after it takes the transaction
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    res = predict_allocation(r);
    if (typed) res = lit;
    replies_due.push_back(res);
  endtask

  // max_slots is only written with no transaction in flight. Every request
  // yields a result, so an empty result queue means the block is idle.
  task automatic write_max_slots(input logic [10:0] val);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_slots_m = val;
  endtask

  // Receiver stall pattern, one draw per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result: index %h gen %h live %b status %0d",
                 $time, out_result_index, out_result_generation,
                 out_handle_live, out_status);
        fail_cnt++;
      end else begin
        want = replies_due.pop_front();
        if (out_result_index !== want.index) begin
          $display("%0t: result_index expected %h got %h",
                   $time, want.index, out_result_index);
          fail_cnt++;
        end
        if (out_result_generation !== want.gen) begin
          $display("%0t: result_generation expected %h got %h",
                   $time, want.gen, out_result_generation);
          fail_cnt++;
        end
        if (out_handle_live !== want.live) begin
          $display("%0t: handle_live expected %b got %b",
                   $time, want.live, out_handle_live);
          fail_cnt++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d",
                   $time, want.status, out_status);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    req_t        r;
    int unsigned lim;
    int          near;
    int unsigned pick;
    logic [10:0] val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // in_ready stays low through the clearing pass; the handshake waits it out

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG)
        write_max_slots(PLAN[i].cfg_val);
      else
        send_request('{PLAN[i].mode, PLAN[i].index, PLAN[i].gen},
                     PLAN[i].kind == ROW_LIT, PLAN[i].res);
    end

    // Random phases, each at its own max_slots setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle = 81;
        recv_idle = 35;
      end
      if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      val = (ph == RAND_PHASES - 1) ? 11'($urandom_range(2, 1023)) : PHASE_MAX[ph];
      write_max_slots(val);
      lim = pool_limit();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) r.mode = MODE_CREATE;
        else if (pick < 63) r.mode = MODE_DESTROY;
        else if (pick < 94) r.mode = MODE_CHECK;
        else r.mode = MODE_NOP;

        // mostly live indices, some at the limit edge, some anywhere
        pick = $urandom_range(0, 9);
        if (lim > 0 && pick < 6) begin
          r.index = 24'($urandom_range(0, lim - 1));
        end else if (pick < 8) begin
          near = int'(lim) - 1 + int'($urandom_range(0, 2));
          r.index = (near < 0) ? 24'd0 : 24'(near);
        end else begin
          r.index = 24'($urandom);
        end

        // generation: often the current one, so checks hit live handles
        pick = $urandom_range(0, 9);
        if (r.index < SLOTS && pick < 5) r.gen = slot_gen_m[r.index];
        else if (r.index < SLOTS && pick == 5) r.gen = slot_gen_m[r.index] - 8'd1;
        else r.gen = 8'($urandom);

        send_request(r, 1'b0, NO_RSP);
      end
    end

    // Drain, then wait on to catch stray results.
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
